@@ hdl/q_learning_table_engine_core_defines.svh @@
// Assertion macros for the Q-table engine.
// No dependencies; included by the modules that check themselves.
`ifndef Q_LEARNING_TABLE_ENGINE_CORE_DEFINES_SVH
`define Q_LEARNING_TABLE_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define QLTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define QLTE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/qlte_pkg.sv @@
// Shared constants, types and register map of the Q-table engine.
// No dependencies.
package qlte_pkg;

  localparam int NUM_STATES  = 64;
  localparam int NUM_ACTIONS = 8;
  localparam int VALUE_WIDTH = 16;

  localparam int ST_W    = $clog2(NUM_STATES);
  localparam int AC_W    = $clog2(NUM_ACTIONS);
  localparam int ADDR_W  = ST_W + AC_W;
  localparam int DEPTH   = NUM_STATES * NUM_ACTIONS;
  localparam int APB_AW  = 5;

  localparam logic [16:0] ONE_16 = 17'd65536;

  // largest table value and the hot-boot 1.0 capped to it
  localparam int VMAX    = (2 ** (VALUE_WIDTH - 1)) - 1;
  localparam int HOT_ONE = (256 > VMAX) ? VMAX : 256;

  // register reset values
  localparam logic [16:0] RST_LEARNING_RATE   = 17'd6554;
  localparam logic [16:0] RST_DISCOUNT_FACTOR = 17'd58982;
  localparam logic [15:0] RST_DECAY_FACTOR    = 16'd65469;
  localparam logic [16:0] RST_EPSILON_FLOOR   = 17'd655;
  localparam logic [15:0] RST_BOOST_FACTOR    = 16'd4506;
  localparam logic        RST_HOTBOOT_ENABLE  = 1'b0;
  localparam logic [16:0] RST_START_EPSILON   = 17'd65536;
  localparam logic        RST_DECAY_ENABLE    = 1'b1;

  // register indexes
  localparam logic [2:0] REG_LEARNING_RATE   = 3'd0;
  localparam logic [2:0] REG_DISCOUNT_FACTOR = 3'd1;
  localparam logic [2:0] REG_DECAY_FACTOR    = 3'd2;
  localparam logic [2:0] REG_EPSILON_FLOOR   = 3'd3;
  localparam logic [2:0] REG_BOOST_FACTOR    = 3'd4;
  localparam logic [2:0] REG_HOTBOOT_ENABLE  = 3'd5;
  localparam logic [2:0] REG_START_EPSILON   = 3'd6;
  localparam logic [2:0] REG_DECAY_ENABLE    = 3'd7;

  typedef enum logic [1:0] {
    OP_CHOOSE = 2'd0,
    OP_UPDATE = 2'd1,
    OP_BOOST  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef struct packed {
    logic [16:0] learning_rate;
    logic [16:0] discount_factor;
    logic [15:0] decay_factor;
    logic [16:0] epsilon_floor;
    logic [15:0] boost_factor;
    logic        hotboot_enable;
    logic [16:0] start_epsilon;
    logic        decay_enable;
  } cfg_t;

  function automatic logic [16:0] cap16(input logic [16:0] v);
    return (v > ONE_16) ? ONE_16 : v;
  endfunction

endpackage

@@ hdl/qlte_if.sv @@
// Valid/ready channel interfaces for the Q-table engine request and result.
// No dependencies.
interface qlte_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [5:0]  current_state;
  logic [2:0]  taken_action;
  logic [5:0]  succ_state;
  logic signed [15:0] reward;
  logic [6:0]  random_draw;
  logic [2:0]  random_action;

  modport source (output valid, action, current_state, taken_action, succ_state,
                  reward, random_draw, random_action, input ready);
  modport sink   (input valid, action, current_state, taken_action, succ_state,
                  reward, random_draw, random_action, output ready);
endinterface

interface qlte_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  chosen_action;
  logic        explored;
  logic signed [15:0] new_value;
  logic        saturated;
  logic [16:0] epsilon_now;
  logic        decaying;

  modport source (output valid, chosen_action, explored, new_value, saturated,
                  epsilon_now, decaying, input ready);
  modport sink   (input valid, chosen_action, explored, new_value, saturated,
                  epsilon_now, decaying, output ready);
endinterface

@@ hdl/qlte_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module qlte_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ hdl/qlte_cfg.sv @@
// APB-style configuration register file of the Q-table engine.
// Depends on qlte_pkg.
module qlte_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [qlte_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output qlte_pkg::cfg_t             cfg_o
);

  qlte_pkg::cfg_t cfg_q;
  logic [2:0]     idx;
  logic           wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learning_rate   <= qlte_pkg::RST_LEARNING_RATE;
      cfg_q.discount_factor <= qlte_pkg::RST_DISCOUNT_FACTOR;
      cfg_q.decay_factor    <= qlte_pkg::RST_DECAY_FACTOR;
      cfg_q.epsilon_floor   <= qlte_pkg::RST_EPSILON_FLOOR;
      cfg_q.boost_factor    <= qlte_pkg::RST_BOOST_FACTOR;
      cfg_q.hotboot_enable  <= qlte_pkg::RST_HOTBOOT_ENABLE;
      cfg_q.start_epsilon   <= qlte_pkg::RST_START_EPSILON;
      cfg_q.decay_enable    <= qlte_pkg::RST_DECAY_ENABLE;
    end else if (wr_en) begin
      unique case (idx)
        qlte_pkg::REG_LEARNING_RATE:   cfg_q.learning_rate   <= pwdata[16:0];
        qlte_pkg::REG_DISCOUNT_FACTOR: cfg_q.discount_factor <= pwdata[16:0];
        qlte_pkg::REG_DECAY_FACTOR:    cfg_q.decay_factor    <= pwdata[15:0];
        qlte_pkg::REG_EPSILON_FLOOR:   cfg_q.epsilon_floor   <= pwdata[16:0];
        qlte_pkg::REG_BOOST_FACTOR:    cfg_q.boost_factor    <= pwdata[15:0];
        qlte_pkg::REG_HOTBOOT_ENABLE:  cfg_q.hotboot_enable  <= pwdata[0];
        qlte_pkg::REG_START_EPSILON:   cfg_q.start_epsilon   <= pwdata[16:0];
        qlte_pkg::REG_DECAY_ENABLE:    cfg_q.decay_enable    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      qlte_pkg::REG_LEARNING_RATE:   prdata = {15'd0, cfg_q.learning_rate};
      qlte_pkg::REG_DISCOUNT_FACTOR: prdata = {15'd0, cfg_q.discount_factor};
      qlte_pkg::REG_DECAY_FACTOR:    prdata = {16'd0, cfg_q.decay_factor};
      qlte_pkg::REG_EPSILON_FLOOR:   prdata = {15'd0, cfg_q.epsilon_floor};
      qlte_pkg::REG_BOOST_FACTOR:    prdata = {16'd0, cfg_q.boost_factor};
      qlte_pkg::REG_HOTBOOT_ENABLE:  prdata = {31'd0, cfg_q.hotboot_enable};
      qlte_pkg::REG_START_EPSILON:   prdata = {15'd0, cfg_q.start_epsilon};
      qlte_pkg::REG_DECAY_ENABLE:    prdata = {31'd0, cfg_q.decay_enable};
      default:                       prdata = 32'd0;
    endcase
  end

endmodule

@@ hdl/q_learning_table_engine_core.sv @@
// Q-table engine: choose either explores or scans the current row; update scans the
// next-state row (one memory read per action), reads the old entry, then runs three
// multiply stages; boost rescales epsilon; clear writes one table entry per cycle.
// Throughput is one transaction at a time; the result register frees input early.
// After reset a clearing pass zeroes the table; no transaction is taken until it ends.
// Depends on qlte_pkg, qlte_if, qlte_ram, qlte_cfg and the defines header.
`include "q_learning_table_engine_core_defines.svh"
module q_learning_table_engine_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  qlte_in_if.sink                     in_i,
  qlte_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qlte_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int VW = qlte_pkg::VALUE_WIDTH;
  localparam int AW = qlte_pkg::ADDR_W;
  localparam int SW = qlte_pkg::ST_W;
  localparam int CW = qlte_pkg::AC_W;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_EPS, S_EXPL, S_SCAN, S_SCANW, S_QRD, S_QWT,
    S_MULB, S_MULA, S_WR, S_BOOST, S_CLR, S_DONE
  } state_e;

  state_e          state_q;
  qlte_pkg::cfg_t  cfg;

  // transaction registers
  qlte_pkg::op_e   op_q;
  logic [SW-1:0]   cs_q, row_q;
  logic [CW-1:0]   ta_q, ract_q;
  logic signed [15:0] rew_q;
  logic [6:0]      draw_q;

  // epsilon state
  logic [16:0]     eps_q;
  logic            dec_q;

  // sweep / scan counter, hot-boot flag for the sweep
  logic [AW-1:0]   swp_q;
  logic            hot_q;

  // row scan tracking
  logic            rd_vld_q;
  logic [CW-1:0]   rd_idx_q;
  logic signed [VW-1:0] best_val_q;
  logic [CW-1:0]   best_idx_q;

  // update datapath
  logic signed [33:0] gm_q;
  logic signed [VW-1:0] q_q;
  logic signed [17:0] t_q;
  logic signed [35:0] pb_q, pa_q;

  // results
  logic [2:0]      res_ch_q;
  logic            res_ex_q;
  logic signed [15:0] res_nv_q;
  logic            res_sat_q;

  // output register
  logic            ov_q;
  logic [2:0]      o_ch_q;
  logic            o_ex_q;
  logic signed [15:0] o_nv_q;
  logic            o_sat_q;
  logic [16:0]     o_eps_q;
  logic            o_dec_q;

  // memory ports
  logic            we_c, re_c;
  logic [AW-1:0]   waddr_c, raddr_c;
  logic [VW-1:0]   wdata_c, rdata;

  qlte_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  qlte_ram #(
    .DEPTH (qlte_pkg::DEPTH),
    .WIDTH (VW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_c),
    .waddr_i (waddr_c),
    .wdata_i (wdata_c),
    .re_i    (re_c),
    .raddr_i (raddr_c),
    .rdata_o (rdata)
  );

  // arithmetic helpers
  logic [16:0]        alpha_c, gamma_c, beta_c;
  logic [32:0]        decay_prod_c, boost_prod_c;
  logic [20:0]        boost_sh_c;
  logic [23:0]        eps100_c, draw_sh_c;
  logic signed [33:0] gm_rnd_c;
  logic signed [17:0] t_c;
  logic signed [36:0] sum_c, v_c;
  logic signed [VW-1:0] v_sat_c;
  logic               sat_c;
  logic               in_fire, out_load;
  logic               last_col_c;

  assign alpha_c      = qlte_pkg::cap16(cfg.learning_rate);
  assign gamma_c      = qlte_pkg::cap16(cfg.discount_factor);
  assign beta_c       = qlte_pkg::ONE_16 - alpha_c;
  assign decay_prod_c = 33'(eps_q) * 33'(cfg.decay_factor);
  assign boost_prod_c = 33'(eps_q) * 33'(cfg.boost_factor);
  assign boost_sh_c   = boost_prod_c[32:12];
  assign eps100_c     = 24'(eps_q) * 24'd100;
  assign draw_sh_c    = {1'b0, draw_q, 16'd0};
  assign gm_rnd_c     = (gm_q + 34'sd32768) >>> 16;
  assign t_c          = 18'(rew_q) + gm_rnd_c[17:0];
  assign sum_c        = 37'(pb_q) + 37'(pa_q) + 37'sd32768;
  assign v_c          = sum_c >>> 16;
  assign last_col_c   = (swp_q[CW-1:0] == CW'(qlte_pkg::NUM_ACTIONS - 1));

  // saturate the update result
  always_comb begin
    sat_c   = 1'b0;
    v_sat_c = v_c[VW-1:0];
    if (v_c > 37'(qlte_pkg::VMAX)) begin
      sat_c   = 1'b1;
      v_sat_c = VW'(qlte_pkg::VMAX);
    end else if (v_c < -37'(qlte_pkg::VMAX) - 37'sd1) begin
      sat_c   = 1'b1;
      v_sat_c = VW'(-qlte_pkg::VMAX - 1);
    end
  end

  // memory access per state
  always_comb begin
    we_c    = 1'b0;
    re_c    = 1'b0;
    waddr_c = swp_q;
    wdata_c = '0;
    raddr_c = {row_q, swp_q[CW-1:0]};
    unique case (state_q)
      S_INIT, S_CLR: begin
        we_c    = 1'b1;
        wdata_c = (hot_q && last_col_c) ? VW'(qlte_pkg::HOT_ONE) : '0;
      end
      S_SCAN: re_c = 1'b1;
      S_QRD: begin
        re_c    = 1'b1;
        raddr_c = {cs_q, ta_q};
      end
      S_WR: begin
        we_c    = 1'b1;
        waddr_c = {cs_q, ta_q};
        wdata_c = v_sat_c;
      end
      default: ;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_load   = (state_q == S_DONE) && (!ov_q || out_o.ready);

  // control and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      swp_q    <= '0;
      hot_q    <= 1'b0;
      eps_q    <= qlte_pkg::cap16(qlte_pkg::RST_START_EPSILON);
      dec_q    <= qlte_pkg::RST_DECAY_ENABLE;
      rd_vld_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == S_SCAN);
      rd_idx_q <= swp_q[CW-1:0];
      if (rd_vld_q && (rd_idx_q == '0 || $signed(rdata) > best_val_q)) begin
        best_val_q <= $signed(rdata);
        best_idx_q <= rd_idx_q;
      end
      if (ov_q && out_o.ready && !out_load) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          swp_q <= swp_q + 1'b1;
          if (swp_q == AW'(qlte_pkg::DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            op_q      <= qlte_pkg::op_e'(in_i.action);
            cs_q      <= in_i.current_state[SW-1:0];
            ta_q      <= in_i.taken_action[CW-1:0];
            rew_q     <= in_i.reward;
            draw_q    <= in_i.random_draw;
            ract_q    <= in_i.random_action[CW-1:0];
            res_ch_q  <= '0;
            res_ex_q  <= 1'b0;
            res_nv_q  <= '0;
            res_sat_q <= 1'b0;
            swp_q     <= '0;
            unique case (qlte_pkg::op_e'(in_i.action))
              qlte_pkg::OP_CHOOSE: state_q <= S_EPS;
              qlte_pkg::OP_UPDATE: begin
                row_q   <= in_i.succ_state[SW-1:0];
                state_q <= S_SCAN;
              end
              qlte_pkg::OP_BOOST:  state_q <= S_BOOST;
              qlte_pkg::OP_CLEAR: begin
                hot_q   <= cfg.hotboot_enable;
                eps_q   <= qlte_pkg::cap16(cfg.start_epsilon);
                dec_q   <= cfg.decay_enable;
                state_q <= S_CLR;
              end
              default: ;
            endcase
          end
        end
        S_EPS: begin
          if (dec_q) begin
            if (eps_q < cfg.epsilon_floor) begin
              dec_q <= 1'b0;
            end else begin
              eps_q <= decay_prod_c[32:16];
            end
          end
          state_q <= S_EXPL;
        end
        S_EXPL: begin
          if (draw_sh_c < eps100_c) begin
            res_ch_q <= 3'(ract_q);
            res_ex_q <= 1'b1;
            state_q  <= S_DONE;
          end else begin
            row_q   <= cs_q;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          swp_q <= swp_q + 1'b1;
          if (last_col_c) begin
            state_q <= S_SCANW;
          end
        end
        S_SCANW: begin
          // last entry of the row lands at this edge
          state_q <= (op_q == qlte_pkg::OP_CHOOSE) ? S_DONE : S_QRD;
        end
        S_QRD: begin
          if (op_q == qlte_pkg::OP_CHOOSE) begin
            res_ch_q <= 3'(best_idx_q);
          end
          gm_q    <= 34'($signed({1'b0, gamma_c})) * 34'(best_val_q);
          state_q <= S_QWT;
        end
        S_QWT: begin
          q_q     <= $signed(rdata);
          t_q     <= t_c;
          state_q <= S_MULB;
        end
        S_MULB: begin
          pb_q    <= 36'($signed({1'b0, beta_c})) * 36'(q_q);
          state_q <= S_MULA;
        end
        S_MULA: begin
          pa_q    <= 36'($signed({1'b0, alpha_c})) * 36'(t_q);
          state_q <= S_WR;
        end
        S_WR: begin
          res_nv_q  <= 16'(v_sat_c);
          res_sat_q <= sat_c;
          state_q   <= S_DONE;
        end
        S_BOOST: begin
          eps_q   <= (boost_sh_c > 21'(qlte_pkg::ONE_16)) ? qlte_pkg::ONE_16
                                                          : boost_sh_c[16:0];
          dec_q   <= 1'b1;
          state_q <= S_DONE;
        end
        S_CLR: begin
          swp_q <= swp_q + 1'b1;
          if (swp_q == AW'(qlte_pkg::DEPTH - 1)) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          // payload only moves into the output register when it is free
          if (out_load) begin
            if (op_q == qlte_pkg::OP_CHOOSE && !res_ex_q) begin
              o_ch_q <= 3'(best_idx_q);
            end else begin
              o_ch_q <= res_ch_q;
            end
            ov_q    <= 1'b1;
            o_ex_q  <= res_ex_q;
            o_nv_q  <= res_nv_q;
            o_sat_q <= res_sat_q;
            o_eps_q <= eps_q;
            o_dec_q <= dec_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.chosen_action = o_ch_q;
  assign out_o.explored      = o_ex_q;
  assign out_o.new_value     = o_nv_q;
  assign out_o.saturated     = o_sat_q;
  assign out_o.epsilon_now   = o_eps_q;
  assign out_o.decaying      = o_dec_q;

  // checks
  `QLTE_ASSERT_NOW(a_eps_range, 1'b1, eps_q <= qlte_pkg::ONE_16, "epsilon above 1.0")
  `QLTE_ASSERT_NOW(a_we_state, we_c,
    state_q == S_INIT || state_q == S_CLR || state_q == S_WR, "table write out of place")
  `QLTE_ASSERT_NXT(a_fire_busy, in_fire, state_q != S_IDLE, "accepted item not started")
  `QLTE_ASSERT_NXT(a_load_valid, out_load, ov_q, "result lost at load")
  `QLTE_ASSERT_NOW(a_scan_src, rd_vld_q, $past(state_q) == S_SCAN, "row read without scan")

endmodule
